// ===== rtl/vth_pkg.sv =====
// ----------------------------------------------------------------------------
// vth_pkg - shared types and constants for the voltage/temperature histogram
// Bin limits, store geometry, operation and register codes, sequencer states.
// ----------------------------------------------------------------------------
package vth_pkg;

    // store geometry
    localparam int CORES       = 64;
    localparam int COUNT_WIDTH = 32;
    localparam int VBINS       = 20;
    localparam int TBINS       = 15;
    localparam int DEPTH       = CORES * VBINS * TBINS;
    localparam int ADDR_W      = $clog2(DEPTH);

    // field widths
    localparam int OP_W    = 2;
    localparam int CORE_W  = 6;
    localparam int SMP_W   = 16;
    localparam int VBIN_W  = 5;
    localparam int TBIN_W  = 4;
    localparam int OUT_W   = 32;
    localparam int MASK_W  = 64;
    localparam int CIDX_W  = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // shared adder is wide enough for both the counter and a sample compare
    localparam int UNIT_W = (COUNT_WIDTH > SMP_W) ? COUNT_WIDTH : SMP_W;

    // descending upper limits, (lower, upper] rule
    localparam logic [SMP_W-1:0] VLIMIT [VBINS-1] = '{
        16'd974, 16'd966, 16'd958, 16'd950, 16'd942, 16'd934, 16'd926,
        16'd918, 16'd910, 16'd902, 16'd894, 16'd886, 16'd878, 16'd870,
        16'd862, 16'd854, 16'd846, 16'd838, 16'd830};

    localparam logic [SMP_W-1:0] TLIMIT [TBINS-1] = '{
        16'd965, 16'd935, 16'd905, 16'd875, 16'd845, 16'd815, 16'd785,
        16'd755, 16'd725, 16'd695, 16'd665, 16'd635, 16'd605, 16'd575};

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_CORE_MASK = 2'd0,
        REG_INBAND    = 2'd1,
        REG_HIST      = 2'd2
    } t_reg_idx;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_VSRCH = 7'b0000010,
        S_TSRCH = 7'b0000100,
        S_ADDR  = 7'b0001000,
        S_RD    = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_CLEAR = 7'b1000000
    } t_state;

endpackage

// ===== rtl/voltage_temperature_histogram.sv =====
// ----------------------------------------------------------------------------
// voltage_temperature_histogram - per-core 2-D voltage/temperature histogram
// Bins each sample, counts it in a counter memory with one write and one read
// port, reads one counter back or clears the whole store, one beat in and one beat out.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 19200-entry counter memory to zero, one
// entry a cycle, and takes no beat until the sweep is done; a clear op with
// the histogram enabled runs the same sweep before its beat, one with it
// disabled skips it. An add tries one limit per cycle on the shared comparator
// (1 to 19 for voltage, 1 to 14 for temperature); a counted add and a read of
// a valid bin then go through address, memory read and update, any other beat
// straight to update. Each result beat sits in an output register, so a stalled
// master side only holds the block when the next result is ready. Configuration
// is written at any edge with the write enable high.
module voltage_temperature_histogram (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [vth_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [vth_pkg::MASK_W-1:0]   i_cfg_wdata,
    // slave side
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // tdata: core_id[5:0], supply_mv[21:6], temp_dc[37:22],
    //        read_voltage_bin[42:38], read_temp_bin[46:43], zero pad
    input  logic [vth_pkg::S_DATA_W-1:0] i_s_tdata,
    // tuser: op[1:0]
    input  logic [vth_pkg::OP_W-1:0]     i_s_tuser,
    // master side
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // tdata: volt_bin[4:0], temp_bin[8:5], counted[9], hit_count[41:10],
    //        zero pad
    output logic [vth_pkg::M_DATA_W-1:0] o_m_tdata
);
    import vth_pkg::*;

    // configuration registers
    logic [MASK_W-1:0]      r_mask;
    logic                   r_inband;
    logic                   r_hist;

    // sequencer and beat registers
    t_state                 r_state;
    t_op                    r_op;
    logic                   r_hit;
    logic                   r_report;
    logic [CORE_W-1:0]      r_core;
    logic [SMP_W-1:0]       r_vmv;
    logic [SMP_W-1:0]       r_tdc;
    logic [VBIN_W-1:0]      r_vb;
    logic [TBIN_W-1:0]      r_tb;
    logic [VBIN_W-1:0]      r_idx;
    logic [ADDR_W-1:0]      r_addr;
    logic [ADDR_W-1:0]      r_sweep;
    logic [COUNT_WIDTH-1:0] r_rdata;

    // output register
    logic                   r_out_valid;
    logic [VBIN_W-1:0]      r_o_vb;
    logic [TBIN_W-1:0]      r_o_tb;
    logic                   r_o_counted;
    logic [OUT_W-1:0]       r_o_cnt;

    // counter memory
    logic [COUNT_WIDTH-1:0] mem [DEPTH];

    // unpacked input fields
    t_op                    w_in_op;
    logic [CORE_W-1:0]      w_in_core;
    logic [SMP_W-1:0]       w_in_vmv;
    logic [SMP_W-1:0]       w_in_tdc;
    logic [VBIN_W-1:0]      w_in_rvb;
    logic [TBIN_W-1:0]      w_in_rtb;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_core_ok;
    logic                   w_add_hit;
    logic                   w_read_hit;

    // shared adder/comparator
    logic [UNIT_W-1:0]      w_ua;
    logic [UNIT_W-1:0]      w_ub;
    logic                   w_ucin;
    logic [UNIT_W:0]        w_usum;
    logic                   w_gt;

    logic                   w_mem_we;
    logic [ADDR_W-1:0]      w_mem_waddr;
    logic [COUNT_WIDTH-1:0] w_mem_wdata;

    // field unpacking
    assign w_in_op   = t_op'(i_s_tuser);
    assign w_in_core = i_s_tdata[5:0];
    assign w_in_vmv  = i_s_tdata[21:6];
    assign w_in_tdc  = i_s_tdata[37:22];
    assign w_in_rvb  = i_s_tdata[42:38];
    assign w_in_rtb  = i_s_tdata[46:43];

    // handshakes
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W - OUT_W - 1 - TBIN_W - VBIN_W){1'b0}},
                         r_o_cnt, r_o_counted, r_o_tb, r_o_vb};

    // gating of the incoming beat
    assign w_core_ok  = (32'(w_in_core) < CORES);
    assign w_add_hit  = w_core_ok && r_mask[w_in_core] && r_inband && r_hist;
    assign w_read_hit = w_core_ok && (32'(w_in_rvb) < VBINS)
                        && (32'(w_in_rtb) < TBINS);

    // shared unit: a + b + cin; carry out of sample + ~limit means sample > limit
    always_comb begin
        w_ua   = UNIT_W'(r_rdata);
        w_ub   = '0;
        w_ucin = 1'b1;
        if (r_state == S_VSRCH) begin
            w_ua   = UNIT_W'(r_vmv);
            w_ub   = ~UNIT_W'(VLIMIT[r_idx]);
            w_ucin = 1'b0;
        end else if (r_state == S_TSRCH) begin
            w_ua   = UNIT_W'(r_tdc);
            w_ub   = ~UNIT_W'(TLIMIT[r_idx[TBIN_W-1:0]]);
            w_ucin = 1'b0;
        end
    end

    assign w_usum = (UNIT_W+1)'(w_ua) + (UNIT_W+1)'(w_ub) + (UNIT_W+1)'(w_ucin);
    assign w_gt   = w_usum[UNIT_W];

    // memory write selection: sweep or counter update
    assign w_mem_we    = (r_state == S_CLEAR)
                         || ((r_state == S_UPD) && w_out_free && (r_op == OP_ADD)
                             && r_hit);
    assign w_mem_waddr = (r_state == S_CLEAR) ? r_sweep : r_addr;
    assign w_mem_wdata = (r_state == S_CLEAR) ? '0 : w_usum[COUNT_WIDTH-1:0];

    // counter memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rdata <= mem[r_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_inband <= 1'b0;
            r_hist   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CORE_MASK: r_mask   <= i_cfg_wdata;
                REG_INBAND:    r_inband <= i_cfg_wdata[0];
                REG_HIST:      r_hist   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // output register valid: loaded from the update cycle, drained by the sink
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_UPD) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_report    <= 1'b0;
            r_op        <= OP_NONE;
            r_hit       <= 1'b0;
            r_idx       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op   <= w_in_op;
                        r_core <= w_in_core;
                        r_vmv  <= w_in_vmv;
                        r_tdc  <= w_in_tdc;
                        r_idx  <= '0;
                        r_vb   <= '0;
                        r_tb   <= '0;
                        r_hit  <= 1'b0;
                        case (w_in_op)
                            OP_ADD: begin
                                r_hit   <= w_add_hit;
                                r_state <= S_VSRCH;
                            end
                            OP_READ: begin
                                r_vb    <= w_in_rvb;
                                r_tb    <= w_in_rtb;
                                r_hit   <= w_read_hit;
                                r_state <= w_read_hit ? S_ADDR : S_UPD;
                            end
                            OP_CLEAR: begin
                                r_hit    <= r_hist;
                                r_sweep  <= '0;
                                r_report <= 1'b1;
                                r_state  <= r_hist ? S_CLEAR : S_UPD;
                            end
                            default: r_state <= S_UPD;
                        endcase
                    end
                end
                // one voltage limit per cycle
                S_VSRCH: begin
                    if (w_gt || (32'(r_idx) == VBINS - 2)) begin
                        r_vb    <= w_gt ? r_idx : VBIN_W'(VBINS - 1);
                        r_idx   <= '0;
                        r_state <= S_TSRCH;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                // one temperature limit per cycle
                S_TSRCH: begin
                    if (w_gt || (32'(r_idx) == TBINS - 2)) begin
                        r_tb    <= w_gt ? r_idx[TBIN_W-1:0] : TBIN_W'(TBINS - 1);
                        r_state <= r_hit ? S_ADDR : S_UPD;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                // slot = (core * VBINS + vbin) * TBINS + tbin
                S_ADDR: begin
                    r_addr  <= ADDR_W'((32'(r_core) * VBINS + 32'(r_vb)) * TBINS
                                       + 32'(r_tb));
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_UPD;
                end
                // load the result beat once the output register is free
                S_UPD: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                // zeroing sweep, one entry a cycle
                S_CLEAR: begin
                    if (32'(r_sweep) == DEPTH - 1) begin
                        r_state  <= r_report ? S_UPD : S_IDLE;
                    end else begin
                        r_sweep <= r_sweep + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if ((r_state == S_UPD) && w_out_free) begin
            r_o_vb      <= '0;
            r_o_tb      <= '0;
            r_o_counted <= 1'b0;
            r_o_cnt     <= '0;
            case (r_op)
                OP_ADD: begin
                    r_o_vb      <= r_vb;
                    r_o_tb      <= r_tb;
                    r_o_counted <= r_hit;
                    r_o_cnt     <= r_hit ? OUT_W'(w_usum[COUNT_WIDTH-1:0]) : '0;
                end
                OP_READ: begin
                    r_o_vb  <= r_vb;
                    r_o_tb  <= r_tb;
                    r_o_cnt <= r_hit ? OUT_W'(r_rdata) : '0;
                end
                OP_CLEAR: r_o_counted <= r_hit;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    // the memory is written only by the sweep or by a counter update
    a_mem_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == S_CLEAR || r_state == S_UPD))
        else $error("counter memory written outside sweep or update");

    // the address is always followed by the memory read
    a_addr_then_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDR) |=> (r_state == S_RD))
        else $error("address cycle not followed by read cycle");

    // the sweep counter stays inside the store
    a_sweep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (32'(r_sweep) < DEPTH))
        else $error("clearing sweep ran past the store");

    // a clear with the histogram disabled never starts a sweep
    a_clear_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_in_op == OP_CLEAR) && !r_hist) |=> (r_state != S_CLEAR))
        else $error("clear swept the store while disabled");

    // a result is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> r_out_valid)
        else $error("pending result beat lost");
`endif

endmodule
